/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file fsha_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

/* rtl/fsha_pkg.sv */
package fsha_pkg;

  localparam int HEAP_UNITS    = 4096;
  localparam int MAX_BLOCKS    = 64;
  localparam int HEADER_UNITS  = 2;
  localparam int GRANULE_ROUND = 15;

  localparam int ADDR_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SIZE_W  = $clog2(HEAP_UNITS) + 1;
  localparam int ENT_W   = SIZE_W + 1;
  localparam int BADDR_W = SIZE_W + 5;

  localparam logic       CMD_ALLOC = 1'b0;
  localparam logic       CMD_FREE  = 1'b1;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_NULL  = 2'd2;
  localparam logic [1:0] ST_UNK   = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [15:0] req_bytes;
    logic [15:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] data_addr;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_START     = 4'd1,
    OP_SCAN      = 4'd2,
    OP_SEL       = 4'd3,
    OP_SHD_SET   = 4'd4,
    OP_SHIFT     = 4'd5,
    OP_WSPLIT    = 4'd6,
    OP_WPICK     = 4'd7,
    OP_WFREE     = 4'd8,
    OP_MSET      = 4'd9,
    OP_RES_NOFIT = 4'd10,
    OP_RES_UNK   = 4'd11,
    OP_PUSH      = 4'd12
  } dp_op_t;

  typedef struct packed {
    logic in_free;
    logic in_null;
    logic scan_done;
    logic found;
    logic split;
    logic hit;
    logic merge;
    logic sh_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/fsha_ram.sv */
module fsha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/fsha_ctrl.sv */
module fsha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fsha_pkg::dp_stat_t st,
  output fsha_pkg::dp_op_t   op
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ASCAN  = 11'b000_0000_0010,
    S_ASEL   = 11'b000_0000_0100,
    S_SHDSET = 11'b000_0000_1000,
    S_SHD    = 11'b000_0001_0000,
    S_WSPLIT = 11'b000_0010_0000,
    S_WPICK  = 11'b000_0100_0000,
    S_FSCAN  = 11'b000_1000_0000,
    S_FDEC   = 11'b001_0000_0000,
    S_SHU    = 11'b010_0000_0000,
    S_RESP   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = fsha_pkg::OP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = fsha_pkg::OP_START;
          if (!st.in_free) begin
            state_nxt = S_ASCAN;
          end else if (st.in_null) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FSCAN;
          end
        end
      end
      S_ASCAN: begin
        op = fsha_pkg::OP_SCAN;
        if (st.scan_done) state_nxt = S_ASEL;
      end
      S_ASEL: begin
        if (!st.found) begin
          op        = fsha_pkg::OP_RES_NOFIT;
          state_nxt = S_RESP;
        end else begin
          op        = fsha_pkg::OP_SEL;
          state_nxt = st.split ? S_SHDSET : S_WPICK;
        end
      end
      S_SHDSET: begin
        op        = fsha_pkg::OP_SHD_SET;
        state_nxt = S_SHD;
      end
      S_SHD: begin
        op = fsha_pkg::OP_SHIFT;
        if (st.sh_done) state_nxt = S_WSPLIT;
      end
      S_WSPLIT: begin
        op        = fsha_pkg::OP_WSPLIT;
        state_nxt = S_WPICK;
      end
      S_WPICK: begin
        op        = fsha_pkg::OP_WPICK;
        state_nxt = S_RESP;
      end
      S_FSCAN: begin
        op = fsha_pkg::OP_SCAN;
        if (st.scan_done) state_nxt = S_FDEC;
      end
      S_FDEC: begin
        if (!st.hit) begin
          op        = fsha_pkg::OP_RES_UNK;
          state_nxt = S_RESP;
        end else if (st.merge) begin
          op        = fsha_pkg::OP_MSET;
          state_nxt = S_SHU;
        end else begin
          op        = fsha_pkg::OP_WFREE;
          state_nxt = S_RESP;
        end
      end
      S_SHU: begin
        op = fsha_pkg::OP_SHIFT;
        if (st.sh_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          op        = fsha_pkg::OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/fsha_dp.sv */
module fsha_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsha_pkg::in_item_t   in_item,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  fsha_pkg::dp_op_t     op,
  output fsha_pkg::dp_stat_t   st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fsha_pkg::out_item_t  out_item
);

  localparam int AW = fsha_pkg::ADDR_W;
  localparam int CW = fsha_pkg::CNT_W;
  localparam int SW = fsha_pkg::SIZE_W;
  localparam int EW = fsha_pkg::ENT_W;
  localparam int BW = fsha_pkg::BADDR_W;
  localparam logic [SW-1:0] HDR = SW'(fsha_pkg::HEADER_UNITS);
  localparam logic [EW-1:0] ENT_RST =
    {1'b1, SW'(fsha_pkg::HEAP_UNITS - fsha_pkg::HEADER_UNITS)};

  logic [1:0]    strat_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] rover_r;
  logic          wrote0_r;
  logic          cmd_r;
  logic [SW-1:0] need_r;
  logic [15:0]   fa_r;
  logic [CW-1:0] idx_r;
  logic          rd_vld_r, rd_sh_r, rd_dflt_r;
  logic [AW-1:0] rd_idx_r;
  logic [SW-1:0] pre_r;
  logic          mfound_r, hfound_r;
  logic [AW-1:0] mpick_r, hpick_r, pick_r;
  logic [SW-1:0] msz_r, hsz_r, psz_r, moff_r, hoff_r, poff_r;
  logic          split_r;
  logic [BW-1:0] baddr_r;
  logic          hit_r, rok_r;
  logic [AW-1:0] hk_r;
  logic [EW-1:0] cur_r, prv_r, prev_r, nxt_r;
  logic          sh_go_r, sh_dn_r;
  logic [CW-1:0] lim_r;
  logic [1:0]    shr_r;
  logic          out_valid_r;
  fsha_pkg::out_item_t out_item_r, res_r;

  logic          re, we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata, ram_q, ent;
  logic [SW-1:0] e_sz;
  logic          e_fr, fits;
  logic [CW-1:0] nf_start;
  logic          sel_hi;
  logic [AW-1:0] sel_pick;
  logic [SW-1:0] sel_sz, sel_off;
  logic          left, right;
  logic [SW-1:0] new_sz;
  logic [CW-1:0] pick_inc;

  fsha_ram #(.WIDTH(EW), .DEPTH(fsha_pkg::MAX_BLOCKS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_q)
  );

  assign ent  = rd_dflt_r ? ENT_RST : ram_q;
  assign e_sz = ent[SW-1:0];
  assign e_fr = ent[EW-1];
  assign fits = e_fr && (e_sz >= need_r);
  assign nf_start = ({1'b0, rover_r} < count_r) ? {1'b0, rover_r} : '0;

  assign sel_hi   = (strat_r == fsha_pkg::FIT_NEXT) && hfound_r;
  assign sel_pick = sel_hi ? hpick_r : mpick_r;
  assign sel_sz   = sel_hi ? hsz_r : msz_r;
  assign sel_off  = sel_hi ? hoff_r : moff_r;

  assign left   = prv_r[EW-1];
  assign right  = rok_r && nxt_r[EW-1];
  assign new_sz = cur_r[SW-1:0] + (left ? prv_r[SW-1:0] + HDR : '0)
                + (right ? nxt_r[SW-1:0] + HDR : '0);
  assign pick_inc = {1'b0, pick_r} + CW'(1);

  assign re = ((op == fsha_pkg::OP_SCAN) && (idx_r < count_r))
           || ((op == fsha_pkg::OP_SHIFT) && sh_go_r);

  always_comb begin
    we    = 1'b0;
    waddr = pick_r;
    wdata = ent;
    if (rd_vld_r && rd_sh_r) begin
      we    = 1'b1;
      waddr = sh_dn_r ? rd_idx_r + AW'(1) : rd_idx_r - AW'(shr_r);
    end else begin
      case (op)
        fsha_pkg::OP_WSPLIT: begin
          we    = 1'b1;
          waddr = pick_inc[AW-1:0];
          wdata = {1'b1, psz_r - need_r - HDR};
        end
        fsha_pkg::OP_WPICK: begin
          we    = 1'b1;
          wdata = {1'b0, split_r ? need_r : psz_r};
        end
        fsha_pkg::OP_WFREE: begin
          we    = 1'b1;
          waddr = hk_r;
          wdata = {1'b1, cur_r[SW-1:0]};
        end
        fsha_pkg::OP_MSET: begin
          we    = 1'b1;
          waddr = hk_r - AW'(left);
          wdata = {1'b1, new_sz};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_comb begin
    st.in_free   = (in_item.cmd == fsha_pkg::CMD_FREE);
    st.in_null   = (in_item.free_addr == 16'd0);
    st.scan_done = (idx_r == count_r) && !rd_vld_r;
    st.found     = mfound_r;
    st.split     = ({1'b0, sel_sz} > {1'b0, need_r} + {1'b0, HDR})
                && (count_r < CW'(fsha_pkg::MAX_BLOCKS));
    st.hit       = hit_r;
    st.merge     = ((strat_r == fsha_pkg::FIT_BEST) || (strat_r == fsha_pkg::FIT_FIRST))
                && (left || right);
    st.sh_done   = !sh_go_r && !rd_vld_r;
    st.out_free  = !out_valid_r || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strat_r     <= fsha_pkg::FIT_BEST;
      count_r     <= CW'(1);
      rover_r     <= '0;
      wrote0_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      sh_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) strat_r <= cfg_wdata;
      if (we && (waddr == '0)) wrote0_r <= 1'b1;
      rd_vld_r <= re;
      if (op == fsha_pkg::OP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        fsha_pkg::OP_SHD_SET: sh_go_r <= count_r > pick_inc;
        fsha_pkg::OP_MSET: begin
          sh_go_r <= ({1'b0, hk_r} + CW'(1) + CW'(right)) < count_r;
          count_r <= count_r - CW'(left) - CW'(right);
        end
        fsha_pkg::OP_SHIFT: if (sh_go_r && (idx_r == lim_r)) sh_go_r <= 1'b0;
        fsha_pkg::OP_WSPLIT: count_r <= count_r + CW'(1);
        fsha_pkg::OP_WPICK: begin
          if (strat_r == fsha_pkg::FIT_NEXT) begin
            rover_r <= (pick_inc >= count_r) ? '0 : pick_inc[AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (re) begin
      rd_idx_r  <= idx_r[AW-1:0];
      rd_sh_r   <= (op == fsha_pkg::OP_SHIFT);
      rd_dflt_r <= (idx_r == '0) && !wrote0_r;
    end
    if (op == fsha_pkg::OP_PUSH) out_item_r <= res_r;

    case (op)
      fsha_pkg::OP_START: begin
        cmd_r    <= in_item.cmd;
        need_r   <= SW'((17'(in_item.req_bytes) + 17'(fsha_pkg::GRANULE_ROUND)) >> 4);
        fa_r     <= in_item.free_addr;
        idx_r    <= '0;
        pre_r    <= '0;
        mfound_r <= 1'b0;
        hfound_r <= 1'b0;
        baddr_r  <= BW'(fsha_pkg::HEADER_UNITS * 16);
        hit_r    <= 1'b0;
        rok_r    <= 1'b0;
        prev_r   <= '0;
        res_r.data_addr <= 16'd0;
        res_r.status    <= ((in_item.cmd == fsha_pkg::CMD_FREE) && (in_item.free_addr == 16'd0))
                           ? fsha_pkg::ST_NULL : fsha_pkg::ST_DONE;
      end
      fsha_pkg::OP_SCAN: if (re) idx_r <= idx_r + CW'(1);
      fsha_pkg::OP_SEL: begin
        pick_r  <= sel_pick;
        psz_r   <= sel_sz;
        poff_r  <= sel_off;
        split_r <= st.split;
      end
      fsha_pkg::OP_SHD_SET: begin
        idx_r   <= count_r - CW'(1);
        lim_r   <= pick_inc;
        sh_dn_r <= 1'b1;
      end
      fsha_pkg::OP_MSET: begin
        idx_r   <= {1'b0, hk_r} + CW'(1) + CW'(right);
        lim_r   <= count_r - CW'(1);
        sh_dn_r <= 1'b0;
        shr_r   <= 2'(left) + 2'(right);
      end
      fsha_pkg::OP_SHIFT: begin
        if (sh_go_r && (idx_r != lim_r)) idx_r <= sh_dn_r ? idx_r - CW'(1) : idx_r + CW'(1);
      end
      fsha_pkg::OP_WPICK: begin
        res_r.data_addr <= 16'((17'(poff_r) + 17'(HDR)) << 4);
      end
      fsha_pkg::OP_RES_NOFIT: res_r.status <= fsha_pkg::ST_NOFIT;
      fsha_pkg::OP_RES_UNK:   res_r.status <= fsha_pkg::ST_UNK;
      default: ;
    endcase

    // consume one scanned entry
    if (rd_vld_r && !rd_sh_r) begin
      if (cmd_r == fsha_pkg::CMD_ALLOC) begin
        pre_r <= pre_r + HDR + e_sz;
        if (fits && (!mfound_r
            || ((strat_r == fsha_pkg::FIT_BEST) && (e_sz < msz_r))
            || ((strat_r == fsha_pkg::FIT_WORST) && (e_sz > msz_r)))) begin
          mfound_r <= 1'b1;
          mpick_r  <= rd_idx_r;
          msz_r    <= e_sz;
          moff_r   <= pre_r;
        end
        if (fits && !hfound_r && ({1'b0, rd_idx_r} >= nf_start)) begin
          hfound_r <= 1'b1;
          hpick_r  <= rd_idx_r;
          hsz_r    <= e_sz;
          hoff_r   <= pre_r;
        end
      end else begin
        baddr_r <= baddr_r + (BW'(e_sz + HDR) << 4);
        prev_r  <= ent;
        if (!hit_r && (baddr_r == BW'(fa_r))) begin
          hit_r <= 1'b1;
          hk_r  <= rd_idx_r;
          cur_r <= ent;
          prv_r <= prev_r;
        end
        if (hit_r && (rd_idx_r == hk_r + AW'(1))) begin
          rok_r <= 1'b1;
          nxt_r <= ent;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/fit_strategy_heap_allocator.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_item  (cmd, req_bytes, free_addr)
// out     | output    | out_valid / out_ready | out_item (data_addr, status)
// cfg     | input     | cfg_we                | cfg_wdata (fit strategy)
//
// One item at a time; count = blocks in the table (at most 64), the length of the scan.
// Allocate: scan every entry, select a block, and on a split shift the entries behind it up.
// Free: scan every entry to find the block; a merge shifts the entries behind the merged
// ones down. A null free skips the scan.
// Reset (rst_n low, synchronous) restores one free block covering the heap.
// A stalled result holds in the output register; a next item is taken but waits to be pushed.
module fit_strategy_heap_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fsha_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fsha_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata
);

  fsha_pkg::dp_op_t   op;
  fsha_pkg::dp_stat_t st;

  fsha_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .op      (op)
  );

  fsha_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .op       (op),
    .st       (st),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

/* rtl/fsha_chk.sv */
`include "assert_macros.svh"

module fsha_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input fsha_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input fsha_pkg::out_item_t out_item
);

  logic res_fail;

  assign res_fail = out_valid && (out_item.status != fsha_pkg::ST_DONE);

  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK_RST(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_item))
  `ASSERT_CLK_RST(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `ASSERT_CLK_RST(a_fail_no_addr, clk, rst_n, res_fail |-> out_item.data_addr == 16'd0)
  `ASSERT_CLK_RST(a_addr_aligned, clk, rst_n, out_valid |-> out_item.data_addr[3:0] == 4'd0)

endmodule

bind fit_strategy_heap_allocator fsha_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

/* dv/fit_strategy_heap_allocator_test.sv */
module fit_strategy_heap_allocator_test;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fsha_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  fsha_pkg::out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  fit_strategy_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [1:0] model_fit;
  int unsigned blk_size[fsha_pkg::MAX_BLOCKS];
  bit blk_free[fsha_pkg::MAX_BLOCKS];
  int unsigned blk_count;
  int unsigned rover;

  fsha_pkg::out_item_t pending_results[$];
  int errors;
  int unsigned cycle_count;
  bit long_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned block_data_offset(int unsigned k);
    int unsigned start;
    start = 0;
    for (int j = 0; j < k; j++) start += fsha_pkg::HEADER_UNITS + blk_size[j];
    return (start + fsha_pkg::HEADER_UNITS) * 16;
  endfunction

  function automatic void drop_block(int unsigned k);
    for (int unsigned j = k; j + 1 < blk_count; j++) begin
      blk_size[j] = blk_size[j+1];
      blk_free[j] = blk_free[j+1];
    end
    blk_count--;
    blk_size[blk_count] = 0;
    blk_free[blk_count] = 0;
  endfunction

  function automatic void heap_reset();
    for (int j = 0; j < fsha_pkg::MAX_BLOCKS; j++) begin
      blk_size[j] = 0;
      blk_free[j] = 0;
    end
    blk_size[0] = fsha_pkg::HEAP_UNITS - fsha_pkg::HEADER_UNITS;
    blk_free[0] = 1;
    blk_count = 1;
    rover = 0;
    model_fit = fsha_pkg::FIT_BEST;
  endfunction

  function automatic fsha_pkg::out_item_t heap_predict(fsha_pkg::in_item_t it);
    fsha_pkg::out_item_t r;
    int unsigned need, pick, start, c, addr, k;
    bit found, hit;
    r = '0;
    found = 0;
    pick = 0;
    if (it.cmd == fsha_pkg::CMD_ALLOC) begin
      need = (int'(it.req_bytes) + fsha_pkg::GRANULE_ROUND) >> 4;
      if (model_fit == fsha_pkg::FIT_NEXT) begin
        start = (rover < blk_count) ? rover : 0;
        for (int unsigned n = 0; n < blk_count; n++) begin
          c = start + n;
          if (c >= blk_count) c -= blk_count;
          if (blk_free[c] && blk_size[c] >= need) begin
            pick = c;
            found = 1;
            break;
          end
        end
      end else begin
        for (int unsigned j = 0; j < blk_count; j++) begin
          if (!blk_free[j] || blk_size[j] < need) continue;
          if (model_fit == fsha_pkg::FIT_FIRST) begin
            pick = j;
            found = 1;
            break;
          end
          if (!found ||
              (model_fit == fsha_pkg::FIT_BEST && blk_size[j] < blk_size[pick]) ||
              (model_fit == fsha_pkg::FIT_WORST && blk_size[j] > blk_size[pick])) begin
            pick = j;
            found = 1;
          end
        end
      end
      if (!found) begin
        r.status = fsha_pkg::ST_NOFIT;
        return r;
      end
      if (blk_size[pick] > need + fsha_pkg::HEADER_UNITS &&
          blk_count < fsha_pkg::MAX_BLOCKS) begin
        for (int unsigned j = blk_count; j > pick + 1; j--) begin
          blk_size[j] = blk_size[j-1];
          blk_free[j] = blk_free[j-1];
        end
        blk_size[pick+1] = blk_size[pick] - need - fsha_pkg::HEADER_UNITS;
        blk_free[pick+1] = 1;
        blk_count++;
        blk_size[pick] = need;
      end
      blk_free[pick] = 0;
      if (model_fit == fsha_pkg::FIT_NEXT) begin
        rover = pick + 1;
        if (rover >= blk_count) rover = 0;
      end
      r.data_addr = 16'(block_data_offset(pick));
      r.status = fsha_pkg::ST_DONE;
      return r;
    end
    if (it.free_addr == 0) begin
      r.status = fsha_pkg::ST_NULL;
      return r;
    end
    addr = fsha_pkg::HEADER_UNITS * 16;
    hit = 0;
    for (k = 0; k < blk_count; k++) begin
      if (addr == it.free_addr) begin
        hit = 1;
        break;
      end
      addr += (fsha_pkg::HEADER_UNITS + blk_size[k]) * 16;
    end
    if (!hit) begin
      r.status = fsha_pkg::ST_UNK;
      return r;
    end
    blk_free[k] = 1;
    if (model_fit == fsha_pkg::FIT_BEST || model_fit == fsha_pkg::FIT_FIRST) begin
      if (k > 0 && blk_free[k-1]) begin
        blk_size[k-1] += fsha_pkg::HEADER_UNITS + blk_size[k];
        drop_block(k);
        k--;
      end
      if (k + 1 < blk_count && blk_free[k+1]) begin
        blk_size[k] += fsha_pkg::HEADER_UNITS + blk_size[k+1];
        drop_block(k + 1);
      end
    end
    r.status = fsha_pkg::ST_DONE;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    fsha_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result data_addr=%0d status=%0d", out_item.data_addr,
               out_item.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.data_addr !== want.data_addr) begin
          $error("data_addr expected %0d actual %0d", want.data_addr, out_item.data_addr);
          errors++;
        end
        if (out_item.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_item.status);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  initial begin
    int hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(negedge clk);
        long_hold = 0;
        out_ready <= 1'b1;
      end else if (cycle_count[9]) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  int burst_left;

  task automatic send_item(fsha_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    burst_left--;
    // valid drops between items; the block is busy then anyway
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(heap_predict(it));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_fit(logic [1:0] f);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_fit = f;
  endtask

  function automatic fsha_pkg::in_item_t alloc_item(int unsigned bytes);
    fsha_pkg::in_item_t it;
    it.cmd = fsha_pkg::CMD_ALLOC;
    it.req_bytes = 16'(bytes);
    it.free_addr = 16'($urandom());
    return it;
  endfunction

  function automatic fsha_pkg::in_item_t free_item(int unsigned a);
    fsha_pkg::in_item_t it;
    it.cmd = fsha_pkg::CMD_FREE;
    it.req_bytes = 16'($urandom());
    it.free_addr = 16'(a);
    return it;
  endfunction

  // pick a live data offset, mostly of a used block
  function automatic int unsigned live_offset();
    int unsigned k;
    k = $urandom_range(0, blk_count - 1);
    for (int n = 0; n < 4 && blk_free[k]; n++) k = $urandom_range(0, blk_count - 1);
    return block_data_offset(k);
  endfunction

  task automatic test_directed();
    send_item(alloc_item(0));
    send_item(alloc_item(1));
    send_item(alloc_item(16));
    send_item(alloc_item(17));
    send_item(alloc_item(65535));
    send_item(free_item(0));
    send_item(free_item(16'hffff));
    send_item(free_item(33));
    send_item(free_item(32));
    send_item(free_item(32));
    send_item(free_item(live_offset()));
    send_item(alloc_item(64));
    send_item(alloc_item(32));
    send_item(alloc_item((fsha_pkg::HEAP_UNITS - 20) * 16));
    send_item(free_item(16'h8000));
    send_item(alloc_item(16'hfff0));
  endtask

  task automatic test_fill_table();
    // exhaust table entries so whole blocks are handed out
    for (int i = 0; i < 70; i++) send_item(alloc_item($urandom_range(0, 48)));
    for (int i = 0; i < 70; i++) send_item(free_item(live_offset()));
  endtask

  task automatic test_random(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_item(alloc_item($urandom_range(0, 1200)));
      else if (r < 50) send_item(alloc_item($urandom()));
      else if (r < 88) send_item(free_item(live_offset()));
      else if (r < 92) send_item(free_item(0));
      else send_item(free_item($urandom()));
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1;
    for (int i = 0; i < 20; i++) send_item(alloc_item($urandom_range(0, 256)));
    wait_drained();
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    long_hold = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = fsha_pkg::FIT_BEST;
    heap_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    set_fit(fsha_pkg::FIT_WORST);
    test_directed();
    test_random(300);
    set_fit(fsha_pkg::FIT_NEXT);
    test_fill_table();
    test_random(350);
    set_fit(fsha_pkg::FIT_FIRST);
    test_random(350);
    set_fit(fsha_pkg::FIT_BEST);
    test_fill_table();
    test_random(350);
    set_fit(fsha_pkg::FIT_WORST);
    test_random(200);
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/fsha_pkg.sv
rtl/fsha_ram.sv
rtl/fsha_ctrl.sv
rtl/fsha_dp.sv
rtl/fit_strategy_heap_allocator.sv
rtl/fsha_chk.sv
dv/fit_strategy_heap_allocator_test.sv
